[sv/lwp_pkg.sv]
// Package: shared constants, types and coefficient conversion for the Lambert W approximant.
`default_nettype none

package lwp_pkg;

    // Width of the polynomial accumulators and coefficients
    localparam int ACC_W = 64;
    // Fractional bits of the stored coefficients
    localparam int COEF_FRAC = 32;
    // Entries in the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    typedef logic signed [ACC_W-1:0] t_acc;

    // Control that travels alongside each item
    typedef struct packed {
        logic vld;
        logic zero;
    } t_ctl;

    localparam t_acc ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam t_acc ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    // Numerator coefficients P1..P6 in Q.32
    localparam t_acc NUM_Q32 [6] = '{
        64'sd4294967296,  64'sd22115997560, 64'sd35950266305,
        64'sd19061344117, 64'sd1389790030,  -64'sd108061819
    };

    // Denominator coefficients Q0..Q4 in Q.32
    localparam t_acc DEN_Q32 [5] = '{
        64'sd4294967296,  64'sd26410964856, 64'sd55918780217,
        64'sd46816923172, 64'sd12388161160
    };

    // Convert a Q.32 coefficient to the working fraction: round half away
    // from zero on a right shift, saturate on a left shift.
    function automatic t_acc coef_conv(input t_acc c, input int frac);
        logic [ACC_W-1:0] mag;
        logic             neg;
        int               s;
        t_acc             r;
        neg = c[ACC_W-1];
        mag = neg ? (~c + 1'b1) : c;
        r   = '0;
        if (frac <= COEF_FRAC) begin
            s = COEF_FRAC - frac;
            if (s > 0) begin
                mag = (mag + (64'd1 << (s - 1))) >> s;
            end
            r = neg ? t_acc'(~mag + 1'b1) : t_acc'(mag);
        end else begin
            s = frac - COEF_FRAC;
            if (mag > (ACC_MAX >> s)) begin
                r = neg ? ACC_MIN : ACC_MAX;
            end else begin
                mag = mag << s;
                r = neg ? t_acc'(~mag + 1'b1) : t_acc'(mag);
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[sv/lwp_if.sv]
// Interfaces: argument stream in and result stream out, valid/ready handshake.
`default_nettype none

interface lwp_in_if #(
    parameter int DW = 32
);
    logic                 valid;
    logic                 ready;
    logic signed [DW-1:0] x_in;

    modport source (output valid, output x_in, input ready);
    modport sink   (input valid, input x_in, output ready);
endinterface

interface lwp_out_if #(
    parameter int DW = 32
);
    logic                 valid;
    logic                 ready;
    logic signed [DW-1:0] w_out;
    logic                 saturated;
    logic                 denom_error;

    modport source (output valid, output w_out, output saturated, output denom_error,
                    input ready);
    modport sink   (input valid, input w_out, input saturated, input denom_error,
                    output ready);
endinterface

`default_nettype wire

[sv/lwp_front.sv]
// Front: accept arguments, flag a zero argument, hand items to the queue.
`default_nettype none

module lwp_front
    import lwp_pkg::*;
#(
    parameter int DW = 32
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    lwp_in_if.sink       i_in,
    input  wire logic    i_full,
    output logic         o_push,
    output logic [DW:0]  o_data
);

    logic                 r_vld;
    logic signed [DW-1:0] r_x;
    logic                 r_zero;

    // Take a new beat whenever the held one leaves or none is held
    assign i_in.ready = !r_vld || !i_full;
    assign o_push     = r_vld && !i_full;
    assign o_data     = {r_zero, r_x};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_vld <= i_in.valid;
        end
    end

    // Hold argument and its class
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_x    <= i_in.x_in;
            r_zero <= (i_in.x_in == '0);
        end
    end

endmodule

`default_nettype wire

[sv/lwp_queue.sv]
// Queue: short register FIFO between the front and the back.
`default_nettype none

module lwp_queue
    import lwp_pkg::*;
#(
    parameter int W     = 33,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_data,
    output logic              o_full,
    input  wire logic         i_pop,
    output logic              o_vld,
    output logic [W-1:0]      o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [CW-1:0] r_cnt;

    assign o_full = (r_cnt == CW'(DEPTH));
    assign o_vld  = (r_cnt != '0);
    assign o_data = r_mem[r_rp];

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Store the pushed beat
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(DEPTH))
        else $error("queue count beyond depth");

    a_no_overfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");

    a_no_underrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_vld)
        else $error("pop from empty queue");

    a_cnt_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_cnt == $past(r_cnt) + 1'b1))
        else $error("queue count did not follow push");

endmodule

`default_nettype wire

[sv/lwp_step.sv]
// Horner step: acc = sat(C + round(x * acc)) over three stages, for p and optionally q.
`default_nettype none

module lwp_step
    import lwp_pkg::*;
#(
    parameter int   DW    = 32,
    parameter int   FRAC  = 28,
    parameter t_acc CP    = '0,
    parameter t_acc CQ    = '0,
    parameter bit   HAS_Q = 1'b1
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_en,
    input  wire t_ctl                 i_ctl,
    input  wire logic signed [DW-1:0] i_x,
    input  wire t_acc                 i_p,
    input  wire t_acc                 i_q,
    output t_ctl                      o_ctl,
    output logic signed [DW-1:0]      o_x,
    output t_acc                      o_p,
    output t_acc                      o_q
);

    localparam int NXC = (DW + 31) / 32;
    localparam int AW  = NXC * 32;
    localparam int PW  = AW + ACC_W;
    localparam int NPP = NXC * 2;

    t_ctl                 r_ctl1, r_ctl2, r_ctl3;
    logic signed [DW-1:0] r_x1, r_x2, r_x3;
    logic [DW-1:0]        x_abs;
    logic [AW-1:0]        a_mag;
    t_acc                 acc_in  [2];
    t_acc                 acc_out [2];

    assign x_abs     = i_x[DW-1] ? (~i_x + 1'b1) : i_x;
    assign a_mag     = AW'(x_abs);
    assign acc_in[0] = i_p;
    assign acc_in[1] = i_q;
    assign o_ctl     = r_ctl3;
    assign o_x       = r_x3;
    assign o_p       = acc_out[0];
    assign o_q       = acc_out[1];

    // Advance control through the three stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1 <= '0;
            r_ctl2 <= '0;
            r_ctl3 <= '0;
        end else if (i_en) begin
            r_ctl1 <= i_ctl;
            r_ctl2 <= r_ctl1;
            r_ctl3 <= r_ctl2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x1 <= i_x;
            r_x2 <= r_x1;
            r_x3 <= r_x2;
        end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
        localparam t_acc C = (l == 0) ? CP : CQ;

        if (l == 0 || HAS_Q) begin : g_mul
            logic [ACC_W-1:0] b_mag;
            logic [63:0]      r_pp [NPP];
            logic             r_neg;
            logic [PW-1:0]    sum;
            logic [PW-1:0]    sh;
            logic [PW-1:0]    lim;
            logic             over;
            t_acc             prod;
            t_acc             r_prod;
            logic [ACC_W:0]   s65;
            t_acc             acc_nx;
            t_acc             r_acc;

            assign b_mag = acc_in[l][ACC_W-1] ? (~acc_in[l] + 1'b1) : acc_in[l];

            // Form the 32 by 32 partial products of the magnitudes
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    for (int i = 0; i < NXC; i++) begin
                        for (int j = 0; j < 2; j++) begin
                            r_pp[i*2+j] <= 64'(a_mag[i*32 +: 32]) * 64'(b_mag[j*32 +: 32]);
                        end
                    end
                    r_neg <= i_x[DW-1] ^ acc_in[l][ACC_W-1];
                end
            end

            // Sum partials, round half away from zero, saturate
            always_comb begin
                sum = PW'(1) << (FRAC - 1);
                for (int i = 0; i < NXC; i++) begin
                    for (int j = 0; j < 2; j++) begin
                        sum = sum + (PW'(r_pp[i*2+j]) << (32 * (i + j)));
                    end
                end
                sh   = sum >> FRAC;
                lim  = PW'(ACC_MAX) + PW'(r_neg);
                over = (sh > lim);
                if (over) begin
                    prod = r_neg ? ACC_MIN : ACC_MAX;
                end else begin
                    prod = r_neg ? t_acc'(~sh[ACC_W-1:0] + 1'b1) : t_acc'(sh[ACC_W-1:0]);
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_prod <= prod;
                end
            end

            // Add the coefficient with saturation
            always_comb begin
                s65 = {C[ACC_W-1], C} + {r_prod[ACC_W-1], r_prod};
                if (s65[ACC_W] != s65[ACC_W-1]) begin
                    acc_nx = s65[ACC_W] ? ACC_MIN : ACC_MAX;
                end else begin
                    acc_nx = s65[ACC_W-1:0];
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_acc <= acc_nx;
                end
            end

            assign acc_out[l] = r_acc;
        end else begin : g_pass
            t_acc r_d1, r_d2, r_d3;

            // Delay the finished value alongside the other lane
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_d1 <= acc_in[l];
                    r_d2 <= r_d1;
                    r_d3 <= r_d2;
                end
            end

            assign acc_out[l] = r_d3;
        end
    end

endmodule

`default_nettype wire

[sv/lwp_div.sv]
// Divider: pipelined restoring division p*2^FRAC / q, one quotient bit per stage.
`default_nettype none

module lwp_div
    import lwp_pkg::*;
#(
    parameter int DW   = 32,
    parameter int FRAC = 28
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire t_ctl             i_ctl,
    input  wire t_acc             i_p,
    input  wire t_acc             i_q,
    output t_ctl                  o_ctl,
    output logic signed [DW-1:0]  o_w,
    output logic                  o_sat,
    output logic                  o_derr
);

    localparam int NW = 2 * ACC_W;
    localparam logic [DW-1:0] W_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] W_MIN = {1'b1, {(DW-1){1'b0}}};

    logic [ACC_W-1:0] pmag;
    logic [ACC_W-1:0] dq;
    logic [NW-1:0]    nvec;
    logic [NW-1:0]    top;

    t_ctl             r_ctl  [DW+1];
    logic [ACC_W-1:0] r_rem  [DW+1];
    logic [ACC_W-1:0] r_d    [DW+1];
    logic [DW-1:0]    r_low  [DW+1];
    logic [DW-1:0]    r_quo  [DW+1];
    logic             r_neg  [DW+1];
    logic             r_ovf  [DW+1];
    logic             r_derr [DW+1];

    assign pmag = i_p[ACC_W-1] ? (~i_p + 1'b1) : i_p;
    assign dq   = i_q;
    assign nvec = {{ACC_W{1'b0}}, pmag} << FRAC;
    assign top  = nvec >> DW;

    // Prepare: classify the denominator, detect a quotient beyond DW bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl[0] <= '0;
        end else if (i_en) begin
            r_ctl[0] <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= top[ACC_W-1:0];
            r_d[0]    <= dq;
            r_low[0]  <= nvec[DW-1:0];
            r_quo[0]  <= '0;
            r_neg[0]  <= i_p[ACC_W-1];
            r_ovf[0]  <= (top >= {{ACC_W{1'b0}}, dq});
            r_derr[0] <= i_q[ACC_W-1] || (i_q == '0);
        end
    end

    for (genvar k = 1; k <= DW; k++) begin : g_bit
        logic [ACC_W-1:0] rem2;
        logic             ge;

        assign rem2 = {r_rem[k-1][ACC_W-2:0], r_low[k-1][DW-1]};
        assign ge   = (rem2 >= r_d[k-1]);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl[k] <= '0;
            end else if (i_en) begin
                r_ctl[k] <= r_ctl[k-1];
            end
        end

        // Subtract where the divisor fits and shift in the quotient bit
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= ge ? (rem2 - r_d[k-1]) : rem2;
                r_d[k]    <= r_d[k-1];
                r_low[k]  <= r_low[k-1] << 1;
                r_quo[k]  <= {r_quo[k-1][DW-2:0], ge};
                r_neg[k]  <= r_neg[k-1];
                r_ovf[k]  <= r_ovf[k-1];
                r_derr[k] <= r_derr[k-1];
            end
        end
    end

    logic          rnd;
    logic [DW:0]   qr;
    logic [DW:0]   lim;
    logic          sat_nx;
    logic [DW-1:0] w_nx;
    t_ctl          r_ctl_o;
    logic [DW-1:0] r_w;
    logic          r_sat;
    logic          r_derr_o;

    // Round half away from zero, clamp to the output range
    always_comb begin
        rnd    = (r_rem[DW] >= (r_d[DW] - r_rem[DW]));
        qr     = {1'b0, r_quo[DW]} + (DW+1)'(rnd);
        lim    = {2'b00, {(DW-1){1'b1}}} + (DW+1)'(r_neg[DW]);
        sat_nx = r_derr[DW] || r_ovf[DW] || (qr > lim);
        if (sat_nx) begin
            w_nx = r_neg[DW] ? W_MIN : W_MAX;
        end else begin
            w_nx = r_neg[DW] ? (~qr[DW-1:0] + 1'b1) : qr[DW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl_o <= '0;
        end else if (i_en) begin
            r_ctl_o <= r_ctl[DW];
        end
    end

    // Hold the result; a zero argument gives zero with no flags
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_w      <= r_ctl[DW].zero ? '0 : w_nx;
            r_sat    <= r_ctl[DW].zero ? 1'b0 : sat_nx;
            r_derr_o <= r_ctl[DW].zero ? 1'b0 : r_derr[DW];
        end
    end

    assign o_ctl  = r_ctl_o;
    assign o_w    = r_w;
    assign o_sat  = r_sat;
    assign o_derr = r_derr_o;

    a_derr_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ctl_o.vld && r_derr_o) |-> r_sat)
        else $error("denominator error without saturation");

    a_zero_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && r_ctl[DW].vld && r_ctl[DW].zero) |=> (r_w == '0 && !r_sat))
        else $error("zero argument gave nonzero result");

    a_sat_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ctl_o.vld && r_sat) |-> (r_w == W_MAX || r_w == W_MIN))
        else $error("saturated result not at a range end");

endmodule

`default_nettype wire

[sv/lwp_back.sv]
// Back: six Horner steps for p, four of them also for q, then the divider and its output register.
`default_nettype none

module lwp_back
    import lwp_pkg::*;
#(
    parameter int DW   = 32,
    parameter int FRAC = 28
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_vld,
    input  wire logic [DW:0] i_data,
    output logic             o_pop,
    lwp_out_if.source        o_out
);

    localparam int   NSTEP  = 6;
    localparam t_acc P_INIT = coef_conv(NUM_Q32[5], FRAC);
    localparam t_acc Q_INIT = coef_conv(DEN_Q32[4], FRAC);

    logic                 en;
    t_ctl                 s_ctl [NSTEP+1];
    logic signed [DW-1:0] s_x   [NSTEP+1];
    t_acc                 s_p   [NSTEP+1];
    t_acc                 s_q   [NSTEP+1];
    t_ctl                 out_ctl;

    // Advance the whole pipe whenever the output register is free
    assign en    = !out_ctl.vld || o_out.ready;
    assign o_pop = en && i_vld;

    assign s_ctl[0].vld  = i_vld;
    assign s_ctl[0].zero = i_data[DW];
    assign s_x[0]        = i_data[DW-1:0];
    assign s_p[0]        = P_INIT;
    assign s_q[0]        = Q_INIT;

    for (genvar s = 0; s < NSTEP; s++) begin : g_step
        localparam t_acc CP = (s < 5) ? coef_conv(NUM_Q32[(s < 5) ? 4 - s : 0], FRAC) : '0;
        localparam t_acc CQ = (s < 4) ? coef_conv(DEN_Q32[(s < 4) ? 3 - s : 0], FRAC) : '0;

        lwp_step #(
            .DW    (DW),
            .FRAC  (FRAC),
            .CP    (CP),
            .CQ    (CQ),
            .HAS_Q (s < 4)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_ctl   (s_ctl[s]),
            .i_x     (s_x[s]),
            .i_p     (s_p[s]),
            .i_q     (s_q[s]),
            .o_ctl   (s_ctl[s+1]),
            .o_x     (s_x[s+1]),
            .o_p     (s_p[s+1]),
            .o_q     (s_q[s+1])
        );
    end

    lwp_div #(
        .DW   (DW),
        .FRAC (FRAC)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_ctl   (s_ctl[NSTEP]),
        .i_p     (s_p[NSTEP]),
        .i_q     (s_q[NSTEP]),
        .o_ctl   (out_ctl),
        .o_w     (o_out.w_out),
        .o_sat   (o_out.saturated),
        .o_derr  (o_out.denom_error)
    );

    assign o_out.valid = out_ctl.vld;

endmodule

`default_nettype wire

[sv/lambert_w_pade_approx.sv]
// Lambert W (principal branch) by a (6,4) Pade approximant in signed fixed point.
// One argument is accepted per clock and one result leaves per clock when the sink keeps
// up. From input beat to result beat an item passes one front register, the queue, six
// Horner steps of three stages each (partial products, round and saturate, coefficient
// add), one divider set-up stage, DATA_WIDTH one-bit divider stages and the output
// register. A stalled sink holds the whole back end; the two-entry queue and the front
// register keep taking beats until they are full. A non-positive denominator sets both
// flags and clamps the result; a quotient beyond range sets saturated.
`default_nettype none

module lambert_w_pade_approx
    import lwp_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 28
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    lwp_in_if.sink     i_in,
    lwp_out_if.source  o_out
);

    logic              push;
    logic              full;
    logic [DATA_WIDTH:0] f_data;
    logic              q_vld;
    logic [DATA_WIDTH:0] q_data;
    logic              pop;

    lwp_front #(
        .DW (DATA_WIDTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (full),
        .o_push  (push),
        .o_data  (f_data)
    );

    lwp_queue #(
        .W     (DATA_WIDTH + 1),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (f_data),
        .o_full  (full),
        .i_pop   (pop),
        .o_vld   (q_vld),
        .o_data  (q_data)
    );

    lwp_back #(
        .DW   (DATA_WIDTH),
        .FRAC (FRAC_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (q_vld),
        .i_data  (q_data),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire

[sim/lambert_w_pade_approx_tb.sv]
// Testbench for the Lambert W Pade approximant: random and directed arguments, scoreboard check.
`default_nettype none

module lambert_w_pade_approx_tb;
    import lwp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DW       = 32;
    localparam int FB       = 28;
    localparam int N_RAND   = 1350;
    localparam int WD_LIMIT = 20000;

    typedef logic signed [63:0] t_s64;

    // Expected result of one argument
    typedef struct {
        logic signed [DW-1:0] w;
        logic                 sat;
        logic                 derr;
    } t_w_res;

    // Fixed-point helpers for the approximant
    function automatic t_s64 clamp_mag(input logic [127:0] mag, input logic neg);
        t_s64 res;
        if (neg) begin
            if (mag > 128'h8000_0000_0000_0000) res = ACC_MIN;
            else res = t_s64'(-mag[63:0]);
        end else begin
            if (mag > 128'h7FFF_FFFF_FFFF_FFFF) res = ACC_MAX;
            else res = t_s64'(mag[63:0]);
        end
        return res;
    endfunction

    function automatic logic [63:0] abs64(input t_s64 v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

    function automatic t_s64 fx_mul(input t_s64 a, input t_s64 b);
        logic [127:0] m;
        m = {64'd0, abs64(a)} * {64'd0, abs64(b)};
        m = (m + (128'd1 << (FB - 1))) >> FB;
        return clamp_mag(m, a[63] != b[63]);
    endfunction

    function automatic t_s64 fx_add(input t_s64 a, input t_s64 b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return ACC_MAX;
        if (s < -65'sh0_8000_0000_0000_0000) return ACC_MIN;
        return t_s64'(s);
    endfunction

    function automatic t_s64 coef_fb(input t_s64 c);
        logic [63:0] m;
        m = abs64(c);
        m = (m + (64'd1 << (COEF_FRAC - FB - 1))) >> (COEF_FRAC - FB);
        return c[63] ? t_s64'(-m) : t_s64'(m);
    endfunction

    function automatic t_w_res lambert_w_predict(input logic signed [DW-1:0] xv);
        t_s64         x, p, q;
        logic [127:0] num, quo, rem;
        logic [63:0]  lim;
        t_w_res       r;
        x = t_s64'(xv);
        p = coef_fb(NUM_Q32[5]);
        for (int k = 4; k >= 0; k--) p = fx_add(coef_fb(NUM_Q32[k]), fx_mul(x, p));
        p = fx_mul(x, p);
        q = coef_fb(DEN_Q32[4]);
        for (int k = 3; k >= 0; k--) q = fx_add(coef_fb(DEN_Q32[k]), fx_mul(x, q));
        r.sat = 1'b0;
        r.derr = 1'b0;
        if (q <= 0) begin
            r.derr = 1'b1;
            r.sat = 1'b1;
            r.w = p >= 0 ? {1'b0, {(DW-1){1'b1}}} : {1'b1, {(DW-1){1'b0}}};
        end else begin
            num = {64'd0, abs64(p)} << FB;
            quo = num / {64'd0, q};
            rem = num % {64'd0, q};
            if (rem >= {64'd0, q} - rem) quo = quo + 1;
            lim = p[63] ? (64'd1 << (DW - 1)) : (64'd1 << (DW - 1)) - 1;
            if (quo > {64'd0, lim}) begin
                r.sat = 1'b1;
                r.w = p[63] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
            end else begin
                r.w = p[63] ? DW'(-quo[63:0]) : DW'(quo[63:0]);
            end
        end
        return r;
    endfunction

    // Holds the expected results in arrival order
    class w_scoreboard;
        t_w_res pending[$];
        int     errors;

        function void note_arg(input logic signed [DW-1:0] xv);
            pending.push_back(lambert_w_predict(xv));
        endfunction

        function void check_result(input logic signed [DW-1:0] w, input logic sat,
                                   input logic derr);
            t_w_res e;
            if (pending.size() == 0) begin
                $error("result with nothing pending: w_out=%0d", w);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (w !== e.w) begin
                $error("w_out: expected %0d, actual %0d", e.w, w);
                errors++;
            end
            if (sat !== e.sat) begin
                $error("saturated: expected %0b, actual %0b", e.sat, sat);
                errors++;
            end
            if (derr !== e.derr) begin
                $error("denom_error: expected %0b, actual %0b", e.derr, derr);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        stim_done = 1'b0;
    int          idle_cycles = 0;
    w_scoreboard sb = new();

    lwp_in_if  #(.DW(DW)) arg_if ();
    lwp_out_if #(.DW(DW)) res_if ();

    lambert_w_pade_approx #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (arg_if.sink),
        .o_out  (res_if.source)
    );

    always #6 i_clk = ~i_clk;

    initial begin
        arg_if.valid = 1'b0;
        arg_if.x_in = '0;
        res_if.ready = 1'b0;
    end

    // Gap length: mostly short, now and then long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // Drive one argument beat and wait for its acceptance
    task automatic send_arg(input logic signed [DW-1:0] xv);
        arg_if.valid <= 1'b1;
        arg_if.x_in <= xv;
        do @(posedge i_clk); while (!arg_if.ready);
        sb.note_arg(xv);
        @(negedge i_clk);
    endtask

    task automatic send_gap();
        int g;
        g = gap_len();
        if (g > 0) begin
            arg_if.valid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
    endtask

    function automatic logic signed [DW-1:0] rand_arg();
        int r;
        r = $urandom_range(0, 99);
        // Near the pole of the denominator
        if (r < 15) return DW'(-32'sd131533373 + $signed($urandom_range(0, 4000000)) - 2000000);
        if (r < 50) return DW'($signed($urandom_range(0, 32'h2000_0000)) - 32'sh1000_0000);
        if (r < 60) return {DW{1'b1}} ^ DW'($urandom_range(0, 255));
        return DW'($urandom());
    endfunction

    // Argument stream
    initial begin
        logic signed [DW-1:0] dir [$];
        dir = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0, 32'sh1, -32'sh1,
                32'sh1000_0000, -32'sh1000_0000, -32'sh0800_0000,
                -32'sd131533373, -32'sd131533000, -32'sd131534000,
                -32'sh0600_0000, -32'sh0400_0000, 32'sh4000_0000, -32'sh4000_0000,
                32'sh5555_5555, 32'shAAAA_AAAA, 32'sh2000_0000, -32'sh2000_0000};
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        foreach (dir[i]) send_arg(dir[i]);
        for (int n = 0; n < N_RAND; n++) begin
            if (n < 200 || n > 400) send_gap();
            send_arg(rand_arg());
        end
        arg_if.valid <= 1'b0;
        stim_done <= 1'b1;
    end

    // Result sink with random stalls
    initial begin
        int g;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (g > 0) begin
                g--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
                if ($urandom_range(0, 9) == 0) g = gap_len();
            end
        end
    end

    // Check each result beat
    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            sb.check_result(res_if.w_out, res_if.saturated, res_if.denom_error);
        end
    end

    // Watchdog: count cycles without any beat
    always @(posedge i_clk) begin
        if ((arg_if.valid && arg_if.ready) || (res_if.valid && res_if.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // End of run
    initial begin
        fork
            begin
                wait (stim_done);
                while (sb.pending.size() != 0) @(posedge i_clk);
                repeat (DW + 40) @(posedge i_clk);
                if (sb.errors == 0) $display("lambert_w_pade_approx_tb: done, clean");
                else $display("lambert_w_pade_approx_tb: done, errors");
            end
            begin
                wait (idle_cycles >= WD_LIMIT);
                $display("lambert_w_pade_approx_tb: done, errors");
            end
        join_any
        $finish;
    end

endmodule

`default_nettype wire
